// File: hdl/assert_macros.svh
// Assertion macros included by the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSS_ASSERT_IMP(lbl, ante, cons)

`define CSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/css_pkg.sv
package css_pkg;

  localparam int unsigned VALUE_DEPTH   = 1024;
  localparam int unsigned SEGMENT_COUNT = 256;

  localparam int unsigned CountW  = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned VAddrW  = $clog2(VALUE_DEPTH);
  localparam int unsigned SegW    = $clog2(SEGMENT_COUNT);
  localparam int unsigned EnergyW = 16;
  localparam int unsigned CapW    = 32;
  localparam int unsigned SegOutW = 8;

  localparam logic [CapW-1:0] CapReset = 32'd1000;

  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic               mode;
    logic [EnergyW-1:0] energy;
  } css_in_t;

  typedef struct packed {
    logic [EnergyW-1:0] popped_energy;
    logic [1:0]         status;
    logic [SegOutW-1:0] current_segment;
    logic               store_empty;
  } css_out_t;

  typedef struct packed {
    logic [VAddrW-1:0] start;
    logic [CapW-1:0]   sum;
  } seg_entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } css_cmd_t;

  typedef struct packed {
    logic out_busy;
  } css_status_t;

endpackage

// File: hdl/css_ctrl.sv
module css_ctrl import css_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  css_status_t dp_status_i,
  output css_cmd_t    dp_cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_comb begin
    dp_cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    dp_cmd_o.commit  = (state_q == S_EXEC) && !dp_status_i.out_busy;
  end

  assign in_stall_o = stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
            stall_q <= 1'b1;
          end
        end
        S_EXEC: begin
          if (!dp_status_i.out_busy) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hdl/css_dpath.sv
module css_dpath import css_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  css_in_t         in_data_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  css_cmd_t        cmd_i,
  output css_status_t     status_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output css_out_t        out_data_o
);

  logic [CapW-1:0]    cap_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [SegW-1:0]    top_q, top_d;
  logic               mode_q;
  logic [EnergyW-1:0] energy_q;
  logic               out_valid_q;
  css_out_t           out_q, out_d;

  logic [EnergyW-1:0] val_mem [VALUE_DEPTH];
  seg_entry_t         seg_mem [SEGMENT_COUNT];
  logic [EnergyW-1:0] rd_val_q;
  seg_entry_t         rd_seg_q;

  logic               val_we;
  logic [VAddrW-1:0]  val_raddr;
  logic               seg_we;
  logic [SegW-1:0]    seg_waddr;
  seg_entry_t         seg_wdata;

  logic [CapW:0]      sum_ext;
  logic               fits;
  logic [CountW-1:0]  cnt_dec;
  status_e            st;
  logic [EnergyW-1:0] popped;

  assign cnt_dec   = count_q - CountW'(1);
  assign val_raddr = cnt_dec[VAddrW-1:0];
  assign sum_ext   = (CapW+1)'(rd_seg_q.sum) + (CapW+1)'(energy_q);
  assign fits      = sum_ext <= (CapW+1)'(cap_q);

  always_comb begin
    count_d   = count_q;
    top_d     = top_q;
    val_we    = 1'b0;
    seg_we    = 1'b0;
    seg_waddr = top_q;
    seg_wdata = rd_seg_q;
    st        = ST_OK;
    popped    = '0;
    if (mode_q == ModePush) begin
      if (count_q == CountW'(VALUE_DEPTH)) begin
        st = ST_FULL;
      end else if (count_q == '0) begin
        top_d           = '0;
        seg_we          = 1'b1;
        seg_waddr       = '0;
        seg_wdata.start = '0;
        seg_wdata.sum   = CapW'(energy_q);
        val_we          = 1'b1;
        count_d         = count_q + CountW'(1);
      end else if (fits) begin
        seg_we        = 1'b1;
        seg_wdata.sum = sum_ext[CapW-1:0];
        val_we        = 1'b1;
        count_d       = count_q + CountW'(1);
      end else if (top_q == SegW'(SEGMENT_COUNT - 1)) begin
        st = ST_FULL;
      end else begin
        top_d           = top_q + SegW'(1);
        seg_we          = 1'b1;
        seg_waddr       = top_q + SegW'(1);
        seg_wdata.start = count_q[VAddrW-1:0];
        seg_wdata.sum   = CapW'(energy_q);
        val_we          = 1'b1;
        count_d         = count_q + CountW'(1);
      end
    end else begin
      if (count_q == '0) begin
        st = ST_EMPTY;
      end else begin
        count_d       = cnt_dec;
        popped        = rd_val_q;
        seg_we        = 1'b1;
        seg_wdata.sum = rd_seg_q.sum - CapW'(rd_val_q);
        if (cnt_dec == '0) begin
          top_d = '0;
        end else if ((cnt_dec <= CountW'(rd_seg_q.start)) && (top_q != '0)) begin
          top_d = top_q - SegW'(1);
        end
      end
    end
    out_d.popped_energy   = popped;
    out_d.status          = st;
    out_d.current_segment = SegOutW'(top_d);
    out_d.store_empty     = (count_d == '0);
  end

  always_ff @(posedge clk_i) begin
    rd_val_q <= val_mem[val_raddr];
    rd_seg_q <= seg_mem[top_q];
    if (cmd_i.commit && val_we) begin
      val_mem[count_q[VAddrW-1:0]] <= energy_q;
    end
    if (cmd_i.commit && seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= in_data_i.mode;
      energy_q <= in_data_i.energy;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        count_q     <= count_d;
        top_q       <= top_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// File: hdl/capacity_segmented_stack.sv
// An accepted transaction is captured in registers, and the top value and segment entry
// are read from registered memory ports; the result is registered when the update is written
// back. No new transaction is accepted until the previous update has been written back.
// A result waiting at the output holds back only the next update, not the next accept.
// Reset: control state is cleared, the store is empty and the capacity returns to 1000.
// The value and segment memories are not cleared; no unwritten entry is used in a result.
`include "assert_macros.svh"

module capacity_segmented_stack import css_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  css_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output css_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  css_cmd_t    cmd;
  css_status_t dp_status;
  logic        res_empty;
  logic        res_pop_empty;
  logic        pop_empty_clean;

  css_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dp_status_i (dp_status),
    .dp_cmd_o    (cmd)
  );

  css_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign res_empty       = out_valid_o && out_data_o.store_empty;
  assign res_pop_empty   = out_valid_o && (out_data_o.status == ST_EMPTY);
  assign pop_empty_clean = out_data_o.store_empty && (out_data_o.popped_energy == '0);

  `CSS_ASSERT_NEXT(a_accept_blocks_next, in_valid_i && !in_stall_o, in_stall_o)
  `CSS_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_o)
  `CSS_ASSERT_IMP(a_empty_at_segment_zero, res_empty, out_data_o.current_segment == '0)
  `CSS_ASSERT_IMP(a_empty_pop_result, res_pop_empty, pop_empty_clean)

endmodule
